@@ rtl/core/pespk_pkg.sv @@
// Shared types, constants and header byte table for the PES packetiser.
`timescale 1ns / 1ps

package pespk_pkg;

  localparam int UNIT_LENGTH_BITS_DEF = 24;

  localparam logic [15:0] LIM_RESET   = 16'd4096;
  localparam logic [15:0] PAYLOAD_CAP = 16'd65525;

  // Header length field counts the rest of the header plus the payload.
  localparam logic [15:0] REST_SHORT = 16'd5;
  localparam logic [15:0] REST_STAMP = 16'd10;

  // Position of the payload byte within one item's run of results.
  localparam logic [4:0] POS_NONE  = 5'd0;
  localparam logic [4:0] POS_SHORT = 5'd11;
  localparam logic [4:0] POS_STAMP = 5'd16;

  localparam logic [7:0] SC_0      = 8'h00;
  localparam logic [7:0] SC_1      = 8'h00;
  localparam logic [7:0] SC_2      = 8'h01;
  localparam logic [7:0] SC_STREAM = 8'hE0;
  localparam logic [7:0] FLAGS_1   = 8'h8C;
  localparam logic [7:0] FLAGS_PTS = 8'h80;
  localparam logic [7:0] HLEN_PTS  = 8'h07;
  localparam logic [7:0] FLAGS_NO  = 8'h00;
  localparam logic [7:0] HLEN_NO   = 8'h02;
  localparam logic [7:0] STUFF_0   = 8'hFF;
  localparam logic [7:0] STUFF_1   = 8'hFC;
  localparam logic [3:0] PTS_PREFIX = 4'b0010;

  typedef enum logic [1:0] {
    HDR_NONE,
    HDR_SHORT,
    HDR_STAMP
  } hdr_kind_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        pend;
    hdr_kind_t   kind;
    logic [15:0] cur;
    logic [32:0] pts;
  } item_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input hdr_kind_t kind,
                                          input logic [15:0] slen, input logic [32:0] pts);
    logic [7:0] b;
    b = SC_0;
    unique case (idx)
      4'd0:  b = SC_0;
      4'd1:  b = SC_1;
      4'd2:  b = SC_2;
      4'd3:  b = SC_STREAM;
      4'd4:  b = slen[15:8];
      4'd5:  b = slen[7:0];
      4'd6:  b = FLAGS_1;
      4'd7:  b = (kind == HDR_STAMP) ? FLAGS_PTS : FLAGS_NO;
      4'd8:  b = (kind == HDR_STAMP) ? HLEN_PTS : HLEN_NO;
      4'd9:  b = (kind == HDR_STAMP) ? {PTS_PREFIX, pts[32:30], 1'b1} : STUFF_0;
      4'd10: b = (kind == HDR_STAMP) ? pts[29:22] : STUFF_1;
      4'd11: b = {pts[21:15], 1'b1};
      4'd12: b = pts[14:7];
      4'd13: b = {pts[6:0], 1'b1};
      4'd14: b = STUFF_0;
      4'd15: b = STUFF_1;
      default: b = SC_0;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/core/pespk_emit.sv @@
// Item register and output register: plays out header bytes then the payload byte.
`timescale 1ns / 1ps

module pespk_emit (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pespk_pkg::item_t item_in,
  output logic            free,
  output logic            item_busy,
  output logic            result_valid,
  input  logic            result_stall,
  output logic [7:0]      out_byte,
  output logic            packet_end,
  output logic            last_of_run
);

  pespk_pkg::item_t item;
  logic             item_valid;
  logic [4:0]       idx;
  logic [4:0]       pay_pos;
  logic [15:0]      slen;
  logic             out_load;
  logic             last;
  logic [7:0]       byte_sel;

  always_comb begin
    unique case (item.kind)
      pespk_pkg::HDR_STAMP: begin
        pay_pos = pespk_pkg::POS_STAMP;
        slen    = item.cur + pespk_pkg::REST_STAMP;
      end
      pespk_pkg::HDR_SHORT: begin
        pay_pos = pespk_pkg::POS_SHORT;
        slen    = item.cur + pespk_pkg::REST_SHORT;
      end
      default: begin
        pay_pos = pespk_pkg::POS_NONE;
        slen    = item.cur;
      end
    endcase
  end

  assign out_load = item_valid && (!result_valid || !result_stall);
  assign last     = (idx == pay_pos);
  assign free     = !item_valid || (out_load && last);
  assign item_busy = item_valid;
  assign byte_sel = last ? item.data : pespk_pkg::hdr_byte(idx[3:0], item.kind, slen, item.pts);

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      idx        <= '0;
    end else if (free) begin
      item_valid <= push;
      idx        <= '0;
    end else if (out_load) begin
      idx <= idx + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (free && push) begin
      item <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      result_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte    <= byte_sel;
      packet_end  <= last && item.pend;
      last_of_run <= last;
    end
  end

endmodule

@@ rtl/core/pes_packetizer.sv @@
// Top level of the PES packetiser: unit and packet counters, limit register, emitter.
// An accepted byte is held in the item register, then its first result in the output register.
// Throughput: one result per cycle while result_stall is low; a payload byte with no header
// gives a single result, one that opens a packet gives header bytes then payload, with a PTS if stamped.
// The input stalls while the item register holds an item whose payload byte is not yet loaded out.
// Reset clears both counters, the valid flags and sets the limit to 4096.
`timescale 1ns / 1ps

module pes_packetizer #(
  parameter int UNIT_LENGTH_BITS = pespk_pkg::UNIT_LENGTH_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [15:0]                 cfg_data,
  input  logic                        data_valid,
  output logic                        data_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        first_of_unit,
  input  logic [UNIT_LENGTH_BITS-1:0] unit_length,
  input  logic [32:0]                 stamp,
  input  logic                        send_stamp,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [7:0]                  out_byte,
  output logic                        packet_end,
  output logic                        last_of_run
);

  localparam int CW = (UNIT_LENGTH_BITS > 16) ? UNIT_LENGTH_BITS : 16;

  logic [15:0]                 lim;
  logic [UNIT_LENGTH_BITS-1:0] unit_bytes_left;
  logic [UNIT_LENGTH_BITS-1:0] unit_bytes_left_next;
  logic [15:0]                 packet_bytes_left;
  logic [15:0]                 packet_bytes_left_next;

  logic [UNIT_LENGTH_BITS-1:0] unit_eff;
  logic [15:0]                 pkt_eff;
  logic [CW-1:0]               unit_w;
  logic [CW-1:0]               lim_w;
  logic [15:0]                 cur;
  logic [15:0]                 pkt_new;
  logic                        accept;
  logic                        drop;
  logic                        need_hdr;
  logic                        push;
  logic                        free;
  logic                        item_busy;
  pespk_pkg::item_t            item_in;

  // Limit is clamped once, at write time.
  always_ff @(posedge clk) begin
    if (rst) begin
      lim <= pespk_pkg::LIM_RESET;
    end else if (cfg_write) begin
      if (cfg_data == 16'd0) begin
        lim <= 16'd1;
      end else if (cfg_data > pespk_pkg::PAYLOAD_CAP) begin
        lim <= pespk_pkg::PAYLOAD_CAP;
      end else begin
        lim <= cfg_data;
      end
    end
  end

  assign accept   = data_valid && !data_stall;
  assign unit_eff = first_of_unit ? unit_length : unit_bytes_left;
  assign pkt_eff  = first_of_unit ? 16'd0 : packet_bytes_left;
  assign drop     = (unit_eff == '0);
  assign need_hdr = (pkt_eff == 16'd0);
  assign unit_w   = CW'(unit_eff);
  assign lim_w    = CW'(lim);
  assign cur      = (unit_w < lim_w) ? unit_w[15:0] : lim;
  assign pkt_new  = need_hdr ? cur : pkt_eff;
  assign push     = accept && !drop;

  always_comb begin
    unit_bytes_left_next   = unit_bytes_left;
    packet_bytes_left_next = packet_bytes_left;
    if (accept) begin
      if (drop) begin
        unit_bytes_left_next   = '0;
        packet_bytes_left_next = 16'd0;
      end else begin
        unit_bytes_left_next   = unit_eff - UNIT_LENGTH_BITS'(1);
        packet_bytes_left_next = pkt_new - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_bytes_left   <= '0;
      packet_bytes_left <= 16'd0;
    end else begin
      unit_bytes_left   <= unit_bytes_left_next;
      packet_bytes_left <= packet_bytes_left_next;
    end
  end

  always_comb begin
    item_in.data = data_byte;
    item_in.pend = (pkt_new == 16'd1);
    item_in.cur  = cur;
    item_in.pts  = stamp;
    if (!need_hdr) begin
      item_in.kind = pespk_pkg::HDR_NONE;
    end else if (first_of_unit && send_stamp) begin
      item_in.kind = pespk_pkg::HDR_STAMP;
    end else begin
      item_in.kind = pespk_pkg::HDR_SHORT;
    end
  end

  assign data_stall = !free;

  pespk_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .item_in      (item_in),
    .free         (free),
    .item_busy    (item_busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .packet_end   (packet_end),
    .last_of_run  (last_of_run)
  );

  // An open packet never holds more bytes than remain in the unit.
  a_pkt_in_unit: assert property (@(posedge clk) disable iff (rst)
    (unit_bytes_left == '0) |-> (packet_bytes_left == 16'd0))
    else $error("open packet outlives its unit");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && packet_end) |-> last_of_run)
    else $error("packet end on a header byte");

  // A header byte is always followed by more of the same run.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_of_run) |=> result_valid)
    else $error("run broken after header byte");

  a_idle_takes: assert property (@(posedge clk) disable iff (rst)
    !item_busy |-> !data_stall)
    else $error("input stalled with empty item register");

endmodule
